@@ design/dcwpd_pkg.sv @@
// Package for the DC-calibrated window peak detector.
// Holds the payload structs, the register indexes, the widths and the
// controller/datapath command and status bundles. No dependencies.
package dcwpd_pkg;

  // Field and state widths.
  localparam int SAMPLE_BITS  = 12;
  localparam int VALUE_BITS   = 12;
  localparam int CHAN_BITS    = 3;
  localparam int WIN_BITS     = 12;
  localparam int CALN_BITS    = 16;
  localparam int SUM_BITS     = 28;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_BITS     = 16;

  // Divider steps: one quotient bit per step.
  localparam int DIV_STEPS     = VALUE_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAL_SAMPLES   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEL_CHANNEL   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_MEAN  = 2'd3;

  // Register reset values.
  localparam logic [WIN_BITS-1:0]   WINDOW_LENGTH_RST = 12'd120;
  localparam logic [CALN_BITS-1:0]  CAL_SAMPLES_RST   = 16'd48000;
  localparam logic [CHAN_BITS-1:0]  SEL_CHANNEL_RST   = 3'd6;
  localparam logic [VALUE_BITS-1:0] INITIAL_MEAN_RST  = 12'd2048;

  // Result kinds.
  localparam logic KIND_MEAN = 1'b0;
  localparam logic KIND_PEAK = 1'b1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [CHAN_BITS-1:0]   channel;
  } item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  kind;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // an input beat is accepted this cycle
    logic div_step;   // run one divider step
    logic emit_mean;  // load the quotient as the mean and present it
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sel_match;    // current input is on the selected channel
    logic calibrating;  // calibration phase still active
    logic cal_full;     // this sample completes the calibration sum
    logic win_close;    // this sample closes a peak window
    logic div_last;     // the divider runs its final step
  } status_t;

endpackage

@@ design/dcwpd_ctrl.sv @@
// Controller for the DC-calibrated window peak detector.
// Sequences accept, the end-of-calibration divide and the output register
// valid flag. Depends on dcwpd_pkg.
module dcwpd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  dcwpd_pkg::status_t status,
  output dcwpd_pkg::cmd_t    cmd
);
  import dcwpd_pkg::*;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       take;
  logic       start_div;
  logic       peak_out;

  // The output register can be loaded when empty or being drained.
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !((state == ST_RUN) && out_free);
  assign take       = item_valid && !item_stall;

  assign start_div = take && status.sel_match && status.calibrating && status.cal_full;
  assign peak_out  = take && status.sel_match && !status.calibrating && status.win_close;

  assign cmd.take      = take;
  assign cmd.div_step  = (state == ST_DIV);
  assign cmd.emit_mean = (state == ST_EMIT) && out_free;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (start_div) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (peak_out || cmd.emit_mean) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/dcwpd_datapath.sv @@
// Datapath for the DC-calibrated window peak detector.
// Holds the configuration registers, calibration sum, restoring divider,
// window peak tracking and the output register. Depends on dcwpd_pkg.
module dcwpd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dcwpd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [dcwpd_pkg::CFG_BITS-1:0]      cfg_data,
  input  dcwpd_pkg::item_t                    item,
  output dcwpd_pkg::result_t                  result,
  input  dcwpd_pkg::cmd_t                     cmd,
  output dcwpd_pkg::status_t                  status
);
  import dcwpd_pkg::*;

  // Configuration registers. The initial mean is held directly in dc_mean.
  logic [WIN_BITS-1:0]   window_length;
  logic [CALN_BITS-1:0]  calibration_samples;
  logic [CHAN_BITS-1:0]  selected_channel;

  // Processing state.
  logic                  calibrating;
  logic [SUM_BITS-1:0]   cal_sum;
  logic [CALN_BITS-1:0]  cal_count;
  logic [VALUE_BITS-1:0] dc_mean;
  logic [WIN_BITS-1:0]   window_count;
  logic [VALUE_BITS-1:0] window_peak;

  // Divider state.
  logic [CALN_BITS-1:0]    div_rem;
  logic [CALN_BITS-1:0]    div_divisor;
  logic [VALUE_BITS-1:0]   div_bits;
  logic [VALUE_BITS-1:0]   div_quot;
  logic [DIV_CNT_BITS-1:0] div_cnt;

  logic [VALUE_BITS-1:0] s;
  logic [SUM_BITS-1:0]   cal_sum_next;
  logic [CALN_BITS-1:0]  cal_count_next;
  logic [CALN_BITS-1:0]  cal_need;
  logic [VALUE_BITS-1:0] dev;
  logic [VALUE_BITS-1:0] window_peak_next;
  logic [WIN_BITS-1:0]   window_count_next;
  logic [WIN_BITS-1:0]   win_need;
  logic [CALN_BITS:0]    div_trial;
  logic                  div_fit;
  logic                  use_sample;

  assign s = VALUE_BITS'(item.sample);

  // Calibration sum and count for the current sample.
  assign cal_sum_next   = cal_sum + SUM_BITS'(s);
  assign cal_count_next = cal_count + 1'b1;
  assign cal_need       = (calibration_samples == '0) ? CALN_BITS'(1) : calibration_samples;

  // Absolute deviation from the mean and the running window peak.
  assign dev               = (s >= dc_mean) ? (s - dc_mean) : (dc_mean - s);
  assign window_peak_next  = (dev > window_peak) ? dev : window_peak;
  assign window_count_next = window_count + 1'b1;
  assign win_need          = (window_length == '0) ? WIN_BITS'(1) : window_length;

  assign status.sel_match   = (item.channel == selected_channel);
  assign status.calibrating = calibrating;
  assign status.cal_full    = (cal_count_next != '0) && (cal_count_next >= cal_need);
  assign status.win_close   = (window_count_next == '0) || (window_count_next >= win_need);
  assign status.div_last    = (div_cnt == '0);

  // One restoring-division step: shift in the next sum bit and try a subtract.
  assign div_trial = {div_rem, div_bits[VALUE_BITS-1]};
  assign div_fit   = (div_trial >= {1'b0, div_divisor});

  assign use_sample = cmd.take && status.sel_match;

  // Configuration registers; an initial_mean write loads the mean below.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length       <= WINDOW_LENGTH_RST;
      calibration_samples <= CAL_SAMPLES_RST;
      selected_channel    <= SEL_CHANNEL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length       <= cfg_data[WIN_BITS-1:0];
        REG_CAL_SAMPLES:   calibration_samples <= cfg_data[CALN_BITS-1:0];
        REG_SEL_CHANNEL:   selected_channel    <= cfg_data[CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Calibration, window tracking and mean.
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating  <= 1'b1;
      cal_sum      <= '0;
      cal_count    <= '0;
      dc_mean      <= INITIAL_MEAN_RST;
      window_count <= '0;
      window_peak  <= '0;
    end else begin
      if (cfg_write && (cfg_index == REG_INITIAL_MEAN) && calibrating) begin
        dc_mean <= cfg_data[VALUE_BITS-1:0];
      end
      if (use_sample && calibrating) begin
        cal_sum   <= cal_sum_next;
        cal_count <= cal_count_next;
      end else if (use_sample) begin
        if (status.win_close) begin
          window_count <= '0;
          window_peak  <= '0;
        end else begin
          window_count <= window_count_next;
          window_peak  <= window_peak_next;
        end
      end
      if (cmd.emit_mean) begin
        dc_mean      <= div_quot;
        calibrating  <= 1'b0;
        window_count <= '0;
        window_peak  <= '0;
      end
    end
  end

  // Iterative divider: the quotient fits in the value width, so the upper sum
  // bits seed the remainder and one quotient bit is formed per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (use_sample && calibrating && status.cal_full) begin
      div_cnt <= DIV_CNT_BITS'(DIV_STEPS - 1);
    end else if (cmd.div_step && !status.div_last) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (use_sample && calibrating && status.cal_full) begin
      div_rem     <= cal_sum_next[SUM_BITS-1:VALUE_BITS];
      div_bits    <= cal_sum_next[VALUE_BITS-1:0];
      div_divisor <= cal_count_next;
      div_quot    <= '0;
    end else if (cmd.div_step) begin
      div_rem  <= div_fit ? CALN_BITS'(div_trial - {1'b0, div_divisor})
                          : div_trial[CALN_BITS-1:0];
      div_bits <= {div_bits[VALUE_BITS-2:0], 1'b0};
      div_quot <= {div_quot[VALUE_BITS-2:0], div_fit};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.emit_mean) begin
      result.value <= div_quot;
      result.kind  <= KIND_MEAN;
    end else if (use_sample && !calibrating && status.win_close) begin
      result.value <= window_peak_next;
      result.kind  <= KIND_PEAK;
    end
  end

endmodule

@@ design/dc_calibrated_window_peak_detector_unit.sv @@
// Top level of the DC-calibrated window peak detector.
// Joins the controller and the datapath. Depends on dcwpd_pkg, dcwpd_ctrl
// and dcwpd_datapath.
//
// Samples on channels other than selected_channel are taken and dropped.
// The first calibration_samples selected samples are summed; the last of them
// starts a 12-step restoring divider (one quotient bit per cycle), after which
// the mean is presented once as a kind 0 beat. From then on the absolute
// deviation from the mean is tracked over windows of window_length selected
// samples and each window peak is presented as a kind 1 beat. One sample is
// taken per cycle while the output register is empty or being drained; the
// calibrating sample that ends the sum stalls further samples through the
// divide and until the mean is presented. Configuration writes take effect on
// the next cycle; an initial_mean write is ignored once calibration ends.
module dc_calibrated_window_peak_detector_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [dcwpd_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [dcwpd_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  dcwpd_pkg::item_t                   item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output dcwpd_pkg::result_t                 result
);
  import dcwpd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing of accepts, the divide and the output valid flag.
  dcwpd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Registers, arithmetic and the output payload.
  dcwpd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
